FILE: hw/rtl/rsg_pkg.sv
// rsg_pkg: shared types, register codes and constants of the resolver signal generator.
// Holds the elaboration-time sine table builder used by rsg_sine_rom.
// No dependencies.
`default_nettype none

package rsg_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PHASE_STEP   = 2'd0,
    CFG_CARRIER_HALF = 2'd1,
    CFG_AMPLITUDE    = 2'd2,
    CFG_PWM_TOP      = 2'd3
  } cfg_reg_e;

  // Input operation codes
  typedef enum logic {
    OP_TICK = 1'b0,
    OP_PARK = 1'b1
  } op_e;

  // Fixed field widths
  localparam int unsigned CfgIndexBits = 2;
  localparam int unsigned CfgDataBits  = 24;
  localparam int unsigned StepBits     = 24;
  localparam int unsigned AngleBits    = 24;
  localparam int unsigned HalfBits     = 10;
  localparam int unsigned AmpBits      = 16;
  localparam int unsigned LevelBits    = 16;
  localparam int unsigned RomBits      = 15;
  localparam int unsigned QueueDepth   = 2;

  // Register reset values
  localparam logic [StepBits-1:0] ResetPhaseStep = '0;
  localparam logic [HalfBits-1:0] ResetHalfTicks = 10'd10;
  localparam logic [AmpBits-1:0]  ResetAmplitude = 16'd26214;
  localparam logic [LevelBits-1:0] ResetPwmTop   = 16'd1023;

  // Q30 constants for the table builder
  localparam longint unsigned Q30One    = 64'd1073741824;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Quarter-wave entry k: sin(pi/2*(2k+1)/2^(addr_bits+1)) in Q1.15, rounded,
  // from a Q30 Taylor series through x^13. Evaluated at elaboration only.
  function automatic logic [RomBits-1:0] sine_entry(input int unsigned k,
                                                    input int unsigned addr_bits);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned p;
    longint unsigned q;
    longint unsigned s;
    int unsigned     m;
    theta = (HalfPiQ30 * longint'(2 * k + 1)) >> (addr_bits + 1);
    t2    = (theta * theta) >> 30;
    p     = Q30One;
    for (m = 12; m >= 2; m = m - 2) begin
      q = (t2 * p) >> 30;
      case (m)
        12:      q = q / 156;
        10:      q = q / 110;
        8:       q = q / 72;
        6:       q = q / 42;
        4:       q = q / 20;
        default: q = q / 6;
      endcase
      p = Q30One - q;
    end
    s = (theta * p) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[RomBits-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rsg_sine_rom.sv
// rsg_sine_rom: quarter-wave sine table, two read ports, registered read data.
// Contents are built at elaboration by rsg_pkg::sine_entry.
`default_nettype none

module rsg_sine_rom import rsg_pkg::*; #(
  parameter int unsigned ADDR_BITS = 10
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [ADDR_BITS-1:0] addr_a_i,
  input  wire logic [ADDR_BITS-1:0] addr_b_i,
  output logic      [RomBits-1:0]   data_a_o,
  output logic      [RomBits-1:0]   data_b_o
);

  localparam int unsigned Depth = 2 ** ADDR_BITS;

  logic [RomBits-1:0] rom_w [Depth];
  logic [RomBits-1:0] data_a_q;
  logic [RomBits-1:0] data_b_q;

  // Constant contents
  for (genvar k = 0; k < Depth; k++) begin : g_entry
    assign rom_w[k] = sine_entry(k, ADDR_BITS);
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      data_a_q <= rom_w[addr_a_i];
      data_b_q <= rom_w[addr_b_i];
    end
  end

  assign data_a_o = data_a_q;
  assign data_b_o = data_b_q;

endmodule

`default_nettype wire

FILE: hw/rtl/rsg_fifo.sv
// rsg_fifo: short queue between the tick front end and the level back end.
// Depth from rsg_pkg::QueueDepth (power of two); width set by parameter.
`default_nettype none

module rsg_fifo import rsg_pkg::*; #(
  parameter int unsigned WIDTH = 37
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] pop_data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrBits = $clog2(QueueDepth);
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  logic [WIDTH-1:0]   mem_q [QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntBits'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: hw/rtl/rsg_front.sv
// rsg_front: accepts input beats, keeps shaft phase, tick count and carrier sign,
// and queues one wave index per tick. Uses rsg_pkg.
`default_nettype none

module rsg_front import rsg_pkg::*; #(
  parameter int unsigned PHASE_BITS     = 24,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  operation_i,
  input  wire logic [AngleBits-1:0]  park_phase_i,
  input  wire logic [StepBits-1:0]   phase_step_i,
  input  wire logic [HalfBits-1:0]   carrier_half_i,
  output logic                       push_o,
  output logic [AngleBits+SINE_ADDR_BITS+2:0] push_data_o,
  input  wire logic                  full_i
);

  localparam int unsigned IdxBits = SINE_ADDR_BITS + 2;
  localparam int          Shift   = int'(PHASE_BITS) - int'(IdxBits);

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [HalfBits-1:0]   tick_q, tick_d;
  logic                  carrier_q, carrier_d;

  logic                  in_fire;
  logic                  is_park;
  logic [PHASE_BITS-1:0] step_ext;
  logic [PHASE_BITS-1:0] phase_add;
  logic [HalfBits:0]     tick_inc;
  logic                  flip;
  logic [IdxBits-1:0]    wave_idx;
  logic [AngleBits-1:0]  angle;

  assign in_ready_o = !full_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_park    = (operation_i == OP_PARK);

  // Phase advance, modulo one turn
  assign step_ext  = PHASE_BITS'($signed(phase_step_i));
  assign phase_add = phase_q + step_ext;

  // Carrier half-period counter
  assign tick_inc = {1'b0, tick_q} + 1'b1;
  assign flip     = (tick_inc >= {1'b0, carrier_half_i});

  // Wave index from the top phase bits
  if (Shift >= 0) begin : g_idx_down
    assign wave_idx = phase_add[Shift +: IdxBits];
  end else begin : g_idx_up
    assign wave_idx = {phase_add, {(IdxBits - PHASE_BITS){1'b0}}};
  end

  assign angle = AngleBits'(phase_add);

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    carrier_d = carrier_q;
    if (in_fire) begin
      if (is_park) begin
        phase_d = PHASE_BITS'(park_phase_i);
      end else begin
        phase_d   = phase_add;
        tick_d    = flip ? '0 : tick_inc[HalfBits-1:0];
        carrier_d = carrier_q ^ flip;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      tick_q    <= '0;
      carrier_q <= 1'b1;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      carrier_q <= carrier_d;
    end
  end

  // Queue entry: carrier after this tick, angle, wave index
  assign push_o      = in_fire && !is_park;
  assign push_data_o = {carrier_q ^ flip, angle, wave_idx};

  // Checks
  a_park_keeps_carrier: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && is_park |=> tick_q == $past(tick_q) && carrier_q == $past(carrier_q))
    else $error("park changed tick count or carrier");
  a_tick_moves_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !is_park |=> phase_q == $past(phase_add))
    else $error("tick did not advance phase");

endmodule

`default_nettype wire

FILE: hw/rtl/rsg_back.sv
// rsg_back: turns a queued wave index into sine and cosine PWM levels.
// Uses rsg_pkg and rsg_sine_rom; one shared multiplier per winding.
`default_nettype none

module rsg_back import rsg_pkg::*; #(
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  input  wire logic [AngleBits+SINE_ADDR_BITS+2:0] pop_data_i,
  input  wire logic [AmpBits-1:0]    amplitude_i,
  input  wire logic [LevelBits-1:0]  pwm_top_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [LevelBits-1:0]       sine_level_o,
  output logic [LevelBits-1:0]       cosine_level_o,
  output logic                       carrier_high_o,
  output logic [AngleBits-1:0]       shaft_angle_o
);

  localparam int unsigned IdxBits = SINE_ADDR_BITS + 2;
  localparam int unsigned LaneSin = 0;
  localparam int unsigned LaneCos = 1;
  localparam logic signed [34:0] DutyHalf = 35'sh0_4000_0000;
  localparam logic signed [34:0] DutyFull = 35'sh0_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCALE = 3'b010,
    ST_LEVEL = 3'b100
  } back_state_e;

  back_state_e state_q, state_d;

  logic                      head_carrier;
  logic [AngleBits-1:0]      head_angle;
  logic [IdxBits-1:0]        head_idx;
  logic [1:0]                quad_s, quad_c;
  logic [SINE_ADDR_BITS-1:0] k_in, addr_s, addr_c;
  logic [RomBits-1:0]        rom_s, rom_c;

  logic [1:0]            neg_q;
  logic                  carrier_q;
  logic [AngleBits-1:0]  angle_q;
  logic [31:0]           duty_q [2];
  logic [31:0]           duty_d [2];

  logic [RomBits-1:0]    rom_val [2];
  logic signed [16:0]    mul_a [2];
  logic signed [32:0]    mul_b [2];
  logic signed [49:0]    prod [2];
  logic signed [34:0]    duty_sum [2];

  logic                  out_free;
  logic                  out_load;
  logic                  out_valid_q, out_valid_d;
  logic [LevelBits-1:0]  sine_level_q, cosine_level_q;
  logic                  carrier_out_q;
  logic [AngleBits-1:0]  angle_out_q;

  // Queue head and table addresses, mirrored in odd quadrants
  assign {head_carrier, head_angle, head_idx} = pop_data_i;
  assign quad_s = head_idx[IdxBits-1 -: 2];
  assign quad_c = quad_s + 2'd1;
  assign k_in   = head_idx[SINE_ADDR_BITS-1:0];
  assign addr_s = quad_s[0] ? ~k_in : k_in;
  assign addr_c = quad_c[0] ? ~k_in : k_in;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  rsg_sine_rom #(
    .ADDR_BITS(SINE_ADDR_BITS)
  ) u_rom (
    .clk_i   (clk_i),
    .rd_en_i (pop_o),
    .addr_a_i(addr_s),
    .addr_b_i(addr_c),
    .data_a_o(rom_s),
    .data_b_o(rom_c)
  );

  assign rom_val[LaneSin] = rom_s;
  assign rom_val[LaneCos] = rom_c;

  // Per winding: scale step forms the duty, level step scales by pwm_top
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (state_q == ST_LEVEL) begin
        mul_a[i] = $signed({1'b0, pwm_top_i});
        mul_b[i] = $signed({1'b0, duty_q[i]});
      end else begin
        mul_a[i] = neg_q[i] ? -$signed({2'b00, rom_val[i]}) : $signed({2'b00, rom_val[i]});
        mul_b[i] = $signed({17'd0, amplitude_i});
      end
      prod[i]     = 50'(mul_a[i]) * 50'(mul_b[i]);
      duty_sum[i] = $signed(prod[i][34:0]) + DutyHalf;
      if (duty_sum[i][34]) begin
        duty_d[i] = '0;
      end else if (duty_sum[i] > DutyFull) begin
        duty_d[i] = DutyFull[31:0];
      end else begin
        duty_d[i] = duty_sum[i][31:0];
      end
    end
  end

  // Output slot
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (state_q == ST_LEVEL) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: state_d = ST_LEVEL;
      ST_LEVEL: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q[LaneSin] <= quad_s[1] ^ ~head_carrier;
      neg_q[LaneCos] <= quad_c[1] ^ ~head_carrier;
      carrier_q      <= head_carrier;
      angle_q        <= head_angle;
    end
    if (state_q == ST_SCALE) begin
      duty_q[LaneSin] <= duty_d[LaneSin];
      duty_q[LaneCos] <= duty_d[LaneCos];
    end
    if (out_load) begin
      sine_level_q   <= prod[LaneSin][46:31];
      cosine_level_q <= prod[LaneCos][46:31];
      carrier_out_q  <= carrier_q;
      angle_out_q    <= angle_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sine_level_o   = sine_level_q;
  assign cosine_level_o = cosine_level_q;
  assign carrier_high_o = carrier_out_q;
  assign shaft_angle_o  = angle_out_q;

  // Checks
  a_pop_starts_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == ST_SCALE) else $error("pop did not start scale step");
  a_level_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished level not shown on output");

endmodule

`default_nettype wire

FILE: hw/rtl/resolver_signal_generator.sv
// resolver_signal_generator: top level, configuration registers and the
// front/queue/back chain. Uses rsg_pkg, rsg_front, rsg_fifo, rsg_back.
//
// Resolver emulator. Each tick beat (operation 0) advances the shaft phase by the
// signed phase_step, counts toward carrier_half_ticks and flips the carrier sign
// when the count is reached, then returns one result beat with the sine and
// cosine PWM levels floor(pwm_top*(1/2 + amplitude*sin/cos*carrier)), the carrier
// sign and the new angle. A park beat (operation 1) sets the phase and returns
// nothing. While the two-entry queue is not full, the front end takes one input
// beat per cycle. For each tick the back end reads the table, forms the duty, then
// the level (one multiplier per winding), registering each step, and takes the
// next tick once the level is in the output slot. Parks never enter the queue.
// Configuration writes are always accepted and must be made while idle.
`default_nettype none

module resolver_signal_generator import rsg_pkg::*; #(
  parameter int unsigned PHASE_BITS     = 24,
  parameter int unsigned SINE_ADDR_BITS = 10
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration write channel
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [CfgDataBits-1:0]  cfg_data_i,
  // input channel
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    operation_i,
  input  wire logic [AngleBits-1:0]    park_phase_i,
  // result channel
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [LevelBits-1:0]         sine_level_o,
  output logic [LevelBits-1:0]         cosine_level_o,
  output logic                         carrier_high_o,
  output logic [AngleBits-1:0]         shaft_angle_o
);

  localparam int unsigned EntryBits = 1 + AngleBits + SINE_ADDR_BITS + 2;

  logic [StepBits-1:0]  phase_step_q;
  logic [HalfBits-1:0]  carrier_half_q;
  logic [AmpBits-1:0]   amplitude_q;
  logic [LevelBits-1:0] pwm_top_q;

  logic                 push;
  logic [EntryBits-1:0] push_data;
  logic                 full;
  logic                 pop;
  logic [EntryBits-1:0] pop_data;
  logic                 empty;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q   <= ResetPhaseStep;
      carrier_half_q <= ResetHalfTicks;
      amplitude_q    <= ResetAmplitude;
      pwm_top_q      <= ResetPwmTop;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PHASE_STEP:   phase_step_q   <= cfg_data_i[StepBits-1:0];
        CFG_CARRIER_HALF: carrier_half_q <= cfg_data_i[HalfBits-1:0];
        CFG_AMPLITUDE:    amplitude_q    <= cfg_data_i[AmpBits-1:0];
        CFG_PWM_TOP:      pwm_top_q      <= cfg_data_i[LevelBits-1:0];
        default: ;
      endcase
    end
  end

  rsg_front #(
    .PHASE_BITS    (PHASE_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .park_phase_i  (park_phase_i),
    .phase_step_i  (phase_step_q),
    .carrier_half_i(carrier_half_q),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  rsg_fifo #(
    .WIDTH(EntryBits)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (empty)
  );

  rsg_back #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_o         (pop),
    .pop_data_i    (pop_data),
    .amplitude_i   (amplitude_q),
    .pwm_top_i     (pwm_top_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sine_level_o  (sine_level_o),
    .cosine_level_o(cosine_level_o),
    .carrier_high_o(carrier_high_o),
    .shaft_angle_o (shaft_angle_o)
  );

endmodule

`default_nettype wire

FILE: test/tb_resolver_signal_generator.sv
// tb_resolver_signal_generator: self-checking testbench of the resolver signal generator.
// Predicts every result beat with its own model of phase, carrier and PWM level math.
// Depends on rsg_pkg and resolver_signal_generator.
module tb_resolver_signal_generator;
  import rsg_pkg::*;

  localparam int unsigned DrainCycles = 16;
  localparam int unsigned Phases      = 8;
  localparam int unsigned PhaseItems  = 94;

  typedef struct {
    op_e                  op;
    logic [AngleBits-1:0] phase;
  } tick_beat_t;

  typedef struct {
    logic [LevelBits-1:0] sine;
    logic [LevelBits-1:0] cosine;
    logic                 carrier;
    logic [AngleBits-1:0] angle;
  } winding_sample_t;

  // DUT signals; all inputs known from time zero
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0]  cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    operation = OP_TICK;
  logic [AngleBits-1:0]    park_phase = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [LevelBits-1:0]    sine_level;
  logic [LevelBits-1:0]    cosine_level;
  logic                    carrier_high;
  logic [AngleBits-1:0]    shaft_angle;

  // Predictor state and register shadows
  logic [AngleBits-1:0] shaft_q = '0;
  logic [HalfBits-1:0]  ticks_q = '0;
  logic                 carrier_q = 1'b1;
  logic [StepBits-1:0]  step_cfg = ResetPhaseStep;
  logic [HalfBits-1:0]  half_cfg = ResetHalfTicks;
  logic [AmpBits-1:0]   amp_cfg = ResetAmplitude;
  logic [LevelBits-1:0] top_cfg = ResetPwmTop;

  tick_beat_t      pending_beats[$];
  winding_sample_t expected_samples[$];
  tick_beat_t      next_beat;
  winding_sample_t got_sample;
  int unsigned     in_gap = 0;
  int unsigned     out_gap = 0;
  int unsigned     fail_count = 0;
  bit              no_idle = 1'b0;

  resolver_signal_generator dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .operation_i    (operation),
    .park_phase_i   (park_phase),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .sine_level_o   (sine_level),
    .cosine_level_o (cosine_level),
    .carrier_high_o (carrier_high),
    .shaft_angle_o  (shaft_angle)
  );

  always #2 clk = ~clk;

  // Quarter-wave table value: Q30 Taylor series of sin, rounded to Q1.15
  function automatic int quarter_sine(int unsigned k);
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned p;
    longint unsigned s;
    int unsigned     m;
    theta = (HalfPiQ30 * longint'(2 * k + 1)) / 64'd2048;
    t2    = (theta * theta) >> 30;
    p     = Q30One;
    for (m = 12; m >= 2; m = m - 2) begin
      p = Q30One - ((t2 * p) >> 30) / longint'(m * (m + 1));
    end
    s = (theta * p) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return int'(s);
  endfunction

  // Full-wave sine from the 12-bit index: mirror odd quadrants, negate the upper half
  function automatic int full_sine(logic [11:0] idx);
    int unsigned k;
    int          v;
    k = idx[9:0];
    if (idx[10]) begin
      k = 1023 - k;
    end
    v = quarter_sine(k);
    return idx[11] ? -v : v;
  endfunction

  // Duty in Q1.31 around the midpoint, saturated, scaled to a floor PWM level
  function automatic logic [LevelBits-1:0] pwm_level(int sv, bit positive);
    longint prod;
    longint duty;
    longint scaled;
    prod = longint'(amp_cfg) * longint'(sv);
    duty = (longint'(1) <<< 30) + (positive ? prod : -prod);
    if (duty < 0) begin
      duty = 0;
    end
    if (duty > (longint'(1) <<< 31)) begin
      duty = longint'(1) <<< 31;
    end
    scaled = (longint'(top_cfg) * duty) >>> 31;
    return scaled[LevelBits-1:0];
  endfunction

  // Advance predictor state for one accepted beat; ticks queue one sample
  task automatic predict_beat(op_e op, logic [AngleBits-1:0] phase);
    winding_sample_t smp;
    logic [11:0]     idx;
    if (op == OP_PARK) begin
      shaft_q = phase;
    end else begin
      shaft_q = shaft_q + step_cfg;
      if ({1'b0, ticks_q} + 11'd1 >= {1'b0, half_cfg}) begin
        ticks_q   = '0;
        carrier_q = ~carrier_q;
      end else begin
        ticks_q = ticks_q + 1'b1;
      end
      idx         = shaft_q[AngleBits-1 -: 12];
      smp.sine    = pwm_level(full_sine(idx), carrier_q);
      smp.cosine  = pwm_level(full_sine(idx + 12'd1024), carrier_q);
      smp.carrier = carrier_q;
      smp.angle   = shaft_q;
      expected_samples.push_back(smp);
    end
  endtask

  // Mostly short gaps, a few long ones; none in a burst phase
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end
    if (r < 93) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  // Input driver: holds each beat until accepted, then idles or loads the next one
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_beat(op_e'(operation), park_phase);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          next_beat = pending_beats.pop_front();
          in_valid   <= 1'b1;
          operation  <= next_beat.op;
          park_phase <= (next_beat.op == OP_PARK) ? next_beat.phase : AngleBits'($urandom);
          in_gap     <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random backpressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          $error("result beat with no expected sample: angle %0h", shaft_angle);
          fail_count++;
        end else begin
          got_sample = expected_samples.pop_front();
          if (sine_level !== got_sample.sine) begin
            $error("sine_level: expected %0d, actual %0d", got_sample.sine, sine_level);
            fail_count++;
          end
          if (cosine_level !== got_sample.cosine) begin
            $error("cosine_level: expected %0d, actual %0d", got_sample.cosine, cosine_level);
            fail_count++;
          end
          if (carrier_high !== got_sample.carrier) begin
            $error("carrier_high: expected %0d, actual %0d", got_sample.carrier, carrier_high);
            fail_count++;
          end
          if (shaft_angle !== got_sample.angle) begin
            $error("shaft_angle: expected %0h, actual %0h", got_sample.angle, shaft_angle);
            fail_count++;
          end
        end
      end
      if (out_gap != 0) begin
        out_gap   <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          out_gap <= pick_gap();
        end
      end
    end
  end

  // Register write; the shadow follows at the accepting edge
  task automatic write_reg(cfg_reg_e idx, logic [CfgDataBits-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_PHASE_STEP:   step_cfg = data[StepBits-1:0];
      CFG_CARRIER_HALF: half_cfg = data[HalfBits-1:0];
      CFG_AMPLITUDE:    amp_cfg  = data[AmpBits-1:0];
      CFG_PWM_TOP:      top_cfg  = data[LevelBits-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [23:0] step, logic [9:0] half, logic [15:0] amp,
                           logic [15:0] top);
    write_reg(CFG_PHASE_STEP, step);
    write_reg(CFG_CARRIER_HALF, CfgDataBits'(half));
    write_reg(CFG_AMPLITUDE, CfgDataBits'(amp));
    write_reg(CFG_PWM_TOP, CfgDataBits'(top));
  endtask

  task automatic push_beat(op_e op, logic [AngleBits-1:0] phase);
    tick_beat_t b;
    b.op    = op;
    b.phase = phase;
    pending_beats.push_back(b);
  endtask

  // Wait for every beat to go out and every sample to come back, then let parks settle.
  // Checked between edges so the driver's updates of the same edge are all visible.
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_samples.size() != 0) begin
      @(negedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic [23:0] random_step();
    case ($urandom_range(0, 3))
      0:       return 24'($urandom_range(0, 4095));
      1:       return -24'($urandom_range(1, 4095));
      2:       return 24'($urandom);
      default: return ($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000;
    endcase
  endfunction

  function automatic logic [9:0] random_half();
    case ($urandom_range(0, 5))
      0:       return 10'($urandom_range(0, 1023));
      1:       return ($urandom_range(0, 1) != 0) ? 10'd0 : 10'd1023;
      default: return 10'($urandom_range(1, 16));
    endcase
  endfunction

  // Stimulus: directed corners, then random phases with fresh register settings
  initial begin
    int unsigned ph;
    int unsigned n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings, parks at the ends and at quadrant boundaries
    repeat (3) push_beat(OP_TICK, '0);
    push_beat(OP_PARK, 24'hFFFFFF);
    push_beat(OP_TICK, '0);
    push_beat(OP_PARK, 24'h000000);
    push_beat(OP_TICK, '0);
    push_beat(OP_PARK, 24'h400000);
    push_beat(OP_TICK, '0);
    push_beat(OP_PARK, 24'h800000);
    push_beat(OP_TICK, '0);
    push_beat(OP_PARK, 24'hC00000);
    push_beat(OP_TICK, '0);
    drain();

    // Largest step, longest carrier period, saturating amplitude, full top
    write_all(24'h7FFFFF, 10'd1023, 16'hFFFF, 16'hFFFF);
    repeat (4) push_beat(OP_TICK, '0);
    drain();
    // Lowering the period below the running count flips on the next tick
    write_reg(CFG_CARRIER_HALF, CfgDataBits'(2));
    half_cfg = 10'd2;
    repeat (2) push_beat(OP_TICK, '0);
    drain();

    // Most negative step, zero period, zero amplitude, zero top
    write_all(24'h800000, 10'd0, 16'd0, 16'd0);
    repeat (3) push_beat(OP_TICK, '0);
    drain();

    // Unit step, period one, half-scale amplitude, top of one
    write_all(24'h000001, 10'd1, 16'd32768, 16'd1);
    push_beat(OP_PARK, 24'h3FFFFF);
    repeat (2) push_beat(OP_TICK, '0);
    drain();

    for (ph = 0; ph < Phases; ph++) begin
      no_idle = (ph == 3);
      write_all(random_step(), random_half(),
                ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768)),
                ($urandom_range(0, 3) == 0) ? 16'd1023 : 16'($urandom));
      for (n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          push_beat(OP_PARK, 24'($urandom));
        end else begin
          push_beat(OP_TICK, '0);
        end
      end
      drain();
    end
    no_idle = 1'b0;

    if (expected_samples.size() != 0) begin
      $error("%0d expected samples never arrived", expected_samples.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("resolver_signal_generator test passed");
    end else begin
      $display("resolver_signal_generator test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("resolver_signal_generator test failed");
    $finish;
  end

endmodule
